@@ rtl/mbc_pkg.sv @@
package mbc_pkg;

  // Field and datapath widths
  localparam int unsigned SUM_BITS  = 32;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned SEED_BITS = 8;
  localparam int unsigned ZB_BITS   = 3;
  // Bits queued for the serial unit: old sum (re-reduction case) plus one byte
  localparam int unsigned FEED_BITS = SUM_BITS + BYTE_BITS;
  // Bit counter: up to FEED_BITS message bits plus four zero bytes (72)
  localparam int unsigned CNT_BITS  = 7;

  // APB register map
  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_MODULUS    = 2'd0,
    REG_SEED_VALUE = 2'd1,
    REG_ZERO_BYTES = 2'd2
  } mbc_reg_t;

  // Reset values of the configuration registers
  localparam logic [SUM_BITS-1:0]  MODULUS_RST    = 32'hFFFF_FFFB;
  localparam logic [SEED_BITS-1:0] SEED_RST       = 8'h00;
  localparam logic [ZB_BITS-1:0]   ZERO_BYTES_RST = 3'd4;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [SUM_BITS-1:0]  modulus;
    logic [SEED_BITS-1:0] seed_value;
    logic [ZB_BITS-1:0]   zero_bytes;
  } mbc_cfg_t;

  // Load command from the sequencer to the serial reduction unit
  typedef struct packed {
    logic                 load;
    logic [SUM_BITS-1:0]  rem_init;
    logic [FEED_BITS-1:0] bits;
    logic [CNT_BITS-1:0]  nbits;
  } mbc_load_t;

endpackage

@@ rtl/mbc_in_if.sv @@
interface mbc_in_if
  import mbc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] data_byte;
  logic                 last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/mbc_out_if.sv @@
interface mbc_out_if
  import mbc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

@@ rtl/modular_byte_checksum_top.sv @@
// Channel   Dir  Payload                   Transaction
// in_chan   in   data_byte[7:0], last_byte  valid & ready
// out_chan  out  checksum[31:0]             valid & ready
// apb       in   modulus, seed, zero_bytes  psel & penable & pwrite (pready = 1)
//
// Each accepted byte is loaded into the serial remainder unit, which then
// steps through its bits, one message bit per cycle. A last byte also shifts
// in the appended zero bytes (1 to 4) and then posts the checksum. A sum not
// below the modulus (modulus changed mid-message) is fed back in before the byte.
// rst is synchronous; no clearing pass. A waiting result holds the
// sequencer only when the next result is ready before it is taken.
module modular_byte_checksum_top
  import mbc_pkg::*;
#(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  mbc_in_if.sink                   in_chan,
  mbc_out_if.source                out_chan,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam logic [SUM_BITS-1:0] SUM_MASK =
    SUM_BITS'((64'd1 << SUM_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state;
  mbc_cfg_t            cfg;
  mbc_load_t           ld;
  logic [SUM_BITS-1:0] rem;
  logic                last_step;
  logic                awaiting_first;
  logic                final_byte;
  logic                out_valid;
  logic [SUM_BITS-1:0] checksum;
  logic                accept;
  logic                out_free;
  logic [ZB_BITS-1:0]  nz;
  logic [CNT_BITS-1:0] zero_bits;
  logic [CNT_BITS-1:0] msg_bits;

  mbc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbc_serial_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .modulus   (cfg.modulus),
    .rem       (rem),
    .last_step (last_step)
  );

  assign in_chan.ready     = (state == ST_IDLE);
  assign accept            = in_chan.valid && in_chan.ready;
  assign out_chan.valid    = out_valid;
  assign out_chan.checksum = checksum;
  assign out_free          = !out_valid || out_chan.ready;

  // Clamp zero byte count to 1..4
  always_comb begin
    if (cfg.zero_bytes == '0) begin
      nz = ZB_BITS'(1);
    end else if (cfg.zero_bytes > ZB_BITS'(4)) begin
      nz = ZB_BITS'(4);
    end else begin
      nz = cfg.zero_bytes;
    end
    zero_bits = in_chan.last_byte ? {1'b0, nz, 3'b000} : '0;
  end

  // Load command for the remainder unit on each accepted byte
  always_comb begin
    ld       = '0;
    msg_bits = CNT_BITS'(BYTE_BITS);
    if (awaiting_first) begin
      ld.rem_init = '0;
      ld.bits     = {in_chan.data_byte ^ cfg.seed_value, {SUM_BITS{1'b0}}};
    end else if ((cfg.modulus != '0) && (rem >= cfg.modulus)) begin
      // re-reduce the old sum together with the new byte
      ld.rem_init = '0;
      ld.bits     = {rem, in_chan.data_byte};
      msg_bits    = CNT_BITS'(FEED_BITS);
    end else begin
      ld.rem_init = rem;
      ld.bits     = {in_chan.data_byte, {SUM_BITS{1'b0}}};
    end
    ld.load  = accept;
    ld.nbits = msg_bits + zero_bits;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      awaiting_first <= 1'b1;
      final_byte     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // Result valid: set when a checksum is posted, cleared when taken
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state          <= ST_RUN;
            final_byte     <= in_chan.last_byte;
            awaiting_first <= 1'b0;
          end
        end
        ST_RUN: begin
          if (last_step) begin
            state <= final_byte ? ST_DONE : ST_IDLE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            awaiting_first <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      checksum <= rem & SUM_MASK;
    end
  end

endmodule

@@ rtl/mbc_cfg_regs.sv @@
module mbc_cfg_regs
  import mbc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output mbc_cfg_t                 cfg
);

  logic     wr_en;
  mbc_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = mbc_reg_t'(paddr[3:2]);

  // Register writes; addresses past the map are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus    <= MODULUS_RST;
      cfg.seed_value <= SEED_RST;
      cfg.zero_bytes <= ZERO_BYTES_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MODULUS:    cfg.modulus    <= pwdata[SUM_BITS-1:0];
        REG_SEED_VALUE: cfg.seed_value <= pwdata[SEED_BITS-1:0];
        REG_ZERO_BYTES: cfg.zero_bytes <= pwdata[ZB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      REG_MODULUS:    prdata = cfg.modulus;
      REG_SEED_VALUE: prdata = {{(APB_DATA_BITS-SEED_BITS){1'b0}}, cfg.seed_value};
      REG_ZERO_BYTES: prdata = {{(APB_DATA_BITS-ZB_BITS){1'b0}}, cfg.zero_bytes};
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/mbc_serial_rem.sv @@
// Bit-serial restoring remainder: one bit of the message per cycle.
// Holds rem < modulus between steps, so each step needs one compare/subtract.
module mbc_serial_rem
  import mbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  mbc_load_t           ld,
  input  logic [SUM_BITS-1:0] modulus,
  output logic [SUM_BITS-1:0] rem,
  output logic                last_step
);

  logic [FEED_BITS-1:0] feed;
  logic [CNT_BITS-1:0]  cnt;
  logic [SUM_BITS:0]    trial;
  logic [SUM_BITS:0]    diff;
  logic [SUM_BITS-1:0]  rem_step;

  // rem*2 + next bit, minus modulus when it fits
  always_comb begin
    trial = {rem, feed[FEED_BITS-1]};
    diff  = trial - {1'b0, modulus};
    if (modulus == '0) begin
      rem_step = '0;
    end else if (trial >= {1'b0, modulus}) begin
      rem_step = diff[SUM_BITS-1:0];
    end else begin
      rem_step = trial[SUM_BITS-1:0];
    end
  end

  assign last_step = (cnt == CNT_BITS'(1));

  // Bit counter (control)
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ld.load) begin
      cnt <= ld.nbits;
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_BITS'(1);
    end
  end

  // Remainder and feed shift register; zeros shift in behind the data
  always_ff @(posedge clk) begin
    if (ld.load) begin
      rem  <= ld.rem_init;
      feed <= ld.bits;
    end else if (cnt != '0) begin
      rem  <= rem_step;
      feed <= {feed[FEED_BITS-2:0], 1'b0};
    end
  end

endmodule

@@ rtl/mbc_checker.sv @@
module mbc_checker
  import mbc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SUM_BITS-1:0] checksum
);

  // No result right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(checksum))
    else $error("stalled checksum changed");

  // Accepting a byte starts work; no back-to-back byte
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // A result is never posted in the cycle a byte is taken
  a_no_accept_on_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result posted while a byte was accepted");

endmodule

bind modular_byte_checksum_top mbc_checker u_mbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .checksum  (out_chan.checksum)
);
